@@ rtl/rfop_pkg.sv @@
// Shared types, sizes and pointer helpers for the overwrite/peek ring FIFO.
// No dependencies; imported by every module of the block.
package rfop_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_WIDTH = 8;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CALC_W = ((PTR_W > 4) ? PTR_W : 4) + 1;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CALC_W-1:0] calc_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [2:0] {
    KIND_PUSH      = 3'd0,
    KIND_PUSH_OVWR = 3'd1,
    KIND_POP       = 3'd2,
    KIND_PEEK      = 3'd3,
    KIND_RESTART   = 3'd4,
    KIND_DISCARD   = 3'd5
  } kind_t;

  typedef struct packed {
    logic  wr_en;
    ptr_t  wr_addr;
    data_t wr_data;
    logic  rd_en;
    ptr_t  rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic       hit;
    logic       stored;
    logic       dropped;
    logic [3:0] fill;
    logic       empty;
  } status_t;

  function automatic ptr_t next_slot(input ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  // Entries held between the slot after rp and wp.
  function automatic calc_t fill_of(input ptr_t rp, input ptr_t wp);
    ptr_t first;
    first = next_slot(rp);
    if (wp >= first) begin
      return calc_t'(wp) - calc_t'(first);
    end
    return calc_t'(wp) + calc_t'(DEPTH) - calc_t'(first);
  endfunction

  // Advance a pointer by n slots, n below DEPTH.
  function automatic ptr_t ptr_add(input ptr_t p, input calc_t n);
    calc_t sum;
    sum = calc_t'(p) + n;
    if (sum >= calc_t'(DEPTH)) begin
      sum = sum - calc_t'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ rtl/rfop_mem.sv @@
// Slot storage of the ring FIFO: one write port, one registered read port.
// Depends on rfop_pkg for the request type and sizes.
module rfop_mem (
  input  logic              clk,
  input  rfop_pkg::mem_req_t req,
  output rfop_pkg::data_t   rd_data
);
  import rfop_pkg::*;

  data_t slots [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slots[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= slots[req.rd_addr];
    end
  end

endmodule

@@ rtl/rfop_ctrl.sv @@
// Pointer registers and per-item operation decode of the ring FIFO.
// Depends on rfop_pkg; drives the slot memory request and the item status.
module rfop_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [2:0]         kind,
  input  rfop_pkg::data_t    data_in,
  input  logic [3:0]         count,
  output rfop_pkg::mem_req_t req,
  output rfop_pkg::status_t  status
);
  import rfop_pkg::*;

  ptr_t  wp, rp, pc;
  ptr_t  wp_next, rp_next, pc_next;
  ptr_t  wp_inc, rp_inc, pc_inc;
  calc_t fill_cur, fill_after, drop_n;
  mem_req_t req_c;

  assign wp_inc = next_slot(wp);
  assign rp_inc = next_slot(rp);
  assign pc_inc = next_slot(pc);
  assign fill_cur = fill_of(rp, wp);
  assign drop_n = (calc_t'(count) < fill_cur) ? calc_t'(count) : fill_cur;

  always_comb begin
    wp_next = wp;
    rp_next = rp;
    pc_next = pc;
    req_c = '0;
    req_c.wr_addr = wp;
    req_c.wr_data = data_in;
    status.hit = 1'b0;
    status.stored = 1'b0;
    status.dropped = 1'b0;
    unique case (kind_t'(kind))
      KIND_PUSH: begin
        if (wp != rp) begin
          req_c.wr_en = 1'b1;
          wp_next = wp_inc;
          status.stored = 1'b1;
        end
      end
      KIND_PUSH_OVWR: begin
        // A full queue gives up its oldest entry to make room.
        if (wp == rp) begin
          rp_next = rp_inc;
          status.dropped = 1'b1;
        end
        req_c.wr_en = 1'b1;
        wp_next = wp_inc;
        status.stored = 1'b1;
      end
      KIND_POP: begin
        if (rp_inc != wp) begin
          req_c.rd_en = 1'b1;
          req_c.rd_addr = rp_inc;
          rp_next = rp_inc;
          status.hit = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (pc_inc != wp) begin
          req_c.rd_en = 1'b1;
          req_c.rd_addr = pc_inc;
          pc_next = pc_inc;
          status.hit = 1'b1;
        end
      end
      KIND_RESTART: begin
        pc_next = rp;
      end
      KIND_DISCARD: begin
        rp_next = ptr_add(rp, drop_n);
      end
      default: begin
      end
    endcase
    req_c.wr_en = req_c.wr_en & accept;
    req_c.rd_en = req_c.rd_en & accept;
    fill_after = fill_of(rp_next, wp_next);
    status.fill = fill_after[3:0];
    status.empty = (next_slot(rp_next) == wp_next);
  end

  assign req = req_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= ptr_t'(DEPTH - 1);
      pc <= '0;
    end else if (accept) begin
      wp <= wp_next;
      rp <= rp_next;
      pc <= pc_next;
    end
  end

endmodule

@@ rtl/ring_fifo_overwrite_peek.sv @@
// Ring FIFO with overwrite and peek: one operation per item, one result per item.
// The result of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle; the single output register takes a new item
// whenever it is empty or its result is taken in the same cycle.
// Reset (rst, synchronous): pointers to their initial values, output empty,
// input stalled while rst is high; slot contents are left as they are.
module ring_fifo_overwrite_peek (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            kind,
  input  rfop_pkg::data_t       data_in,
  input  logic [3:0]            count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rfop_pkg::data_t       data_out,
  output logic                  data_valid,
  output logic                  stored,
  output logic                  dropped_oldest,
  output logic [3:0]            fill_level,
  output logic                  is_empty
);
  import rfop_pkg::*;

  logic     accept;
  mem_req_t req;
  status_t  status;
  status_t  res;
  data_t    rd_data;

  // No item is taken while the block is held in reset.
  assign in_stall = rst | (out_valid & out_stall);
  assign accept = in_valid & ~in_stall;

  rfop_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .kind    (kind),
    .data_in (data_in),
    .count   (count),
    .req     (req),
    .status  (status)
  );

  rfop_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= status;
    end
  end

  // The memory read register holds its word along with the status register.
  assign data_out = res.hit ? rd_data : '0;
  assign data_valid = res.hit;
  assign stored = res.stored;
  assign dropped_oldest = res.dropped;
  assign fill_level = res.fill;
  assign is_empty = res.empty;

`ifndef ASSERT_OFF
  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");
  a_read_or_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(data_valid && stored))
    else $error("one item both read and stored");
  a_drop_stores: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped_oldest) |-> stored)
    else $error("oldest dropped without storing");
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (fill_level == 4'd0))
    else $error("empty queue reports nonzero fill");
`endif

endmodule
